// ===== rtl/core/hlc_pkg.sv =====
// Shared types and constants for the XY homing and hard-limit controller.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package hlc_pkg;

    // Field widths
    localparam int SEARCH_W = 24;
    localparam int PULL_W   = 20;
    localparam int LOW_W    = 16;
    localparam int WAIT_W   = 22;
    localparam int MODE_W   = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SEARCH_X = 3'd0;
    localparam logic [2:0] REG_SEARCH_Y = 3'd1;
    localparam logic [2:0] REG_PULL_X   = 3'd2;
    localparam logic [2:0] REG_PULL_Y   = 3'd3;
    localparam logic [2:0] REG_STEP_LOW = 3'd4;
    localparam logic [2:0] REG_SETTLE   = 3'd5;
    localparam logic [2:0] REG_DWELL    = 3'd6;
    localparam logic [2:0] REG_MODE     = 3'd7;

    // Register reset values
    localparam logic [SEARCH_W-1:0] RST_SEARCH = 24'd40000;
    localparam logic [PULL_W-1:0]   RST_PULL   = 20'd400;
    localparam logic [LOW_W-1:0]    RST_LOW    = 16'd900;
    localparam logic [WAIT_W-1:0]   RST_SETTLE = 22'd200000;
    localparam logic [WAIT_W-1:0]   RST_DWELL  = 22'd3000000;
    localparam logic [MODE_W-1:0]   RST_MODE   = 4'd8;

    // Mode flag bit positions
    localparam int MODE_X_NEG  = 0;
    localparam int MODE_Y_NEG  = 1;
    localparam int MODE_Z_CONT = 2;
    localparam int MODE_HARD   = 3;

    // Command codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Result codes
    localparam logic [1:0] RC_OK     = 2'd0;
    localparam logic [1:0] RC_FAIL_X = 2'd1;
    localparam logic [1:0] RC_FAIL_Y = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SEARCH_X = 4'd1,
        PH_SETTLE   = 4'd2,
        PH_SEARCH_Y = 4'd3,
        PH_DWELL    = 4'd4,
        PH_PULL_X   = 4'd5,
        PH_PULL_Y   = 4'd6
    } phase_t;

    typedef struct packed {
        logic [SEARCH_W-1:0] search_steps_x;
        logic [SEARCH_W-1:0] search_steps_y;
        logic [PULL_W-1:0]   pulloff_steps_x;
        logic [PULL_W-1:0]   pulloff_steps_y;
        logic [LOW_W-1:0]    step_low_ticks;
        logic [WAIT_W-1:0]   settle_ticks;
        logic [WAIT_W-1:0]   dwell_ticks;
        logic [MODE_W-1:0]   mode_flags;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] cycle_mask;
        logic       pin_x;
        logic       pin_y;
        logic       pin_z;
    } item_t;

    typedef struct packed {
        logic       step_x;
        logic       step_y;
        logic       dir_x;
        logic       dir_y;
        logic       drivers_enabled;
        logic       busy;
        logic       done;
        logic [1:0] code;
        logic       zero_position;
        logic       hard_alarm;
        logic       stop_request;
        logic [2:0] switch_state;
    } res_t;

    // Handshake status from the flow stage to the engine and top level
    typedef struct packed {
        logic adv;
        logic in_valid;
        logic out_valid;
    } flow_t;

endpackage

`default_nettype wire

// ===== rtl/core/hlc_regs.sv =====
// APB-style configuration register file for the homing controller.
// Depends on hlc_pkg for register indexes, widths and reset values.
`default_nettype none

module hlc_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hlc_pkg::DATA_W-1:0] pwdata,
    output logic      [hlc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output hlc_pkg::cfg_t                   cfg
);

    hlc_pkg::cfg_t cfg_reg;
    hlc_pkg::cfg_t cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[hlc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                hlc_pkg::REG_SEARCH_X: cfg_next.search_steps_x  = pwdata[hlc_pkg::SEARCH_W-1:0];
                hlc_pkg::REG_SEARCH_Y: cfg_next.search_steps_y  = pwdata[hlc_pkg::SEARCH_W-1:0];
                hlc_pkg::REG_PULL_X:   cfg_next.pulloff_steps_x = pwdata[hlc_pkg::PULL_W-1:0];
                hlc_pkg::REG_PULL_Y:   cfg_next.pulloff_steps_y = pwdata[hlc_pkg::PULL_W-1:0];
                hlc_pkg::REG_STEP_LOW: cfg_next.step_low_ticks  = pwdata[hlc_pkg::LOW_W-1:0];
                hlc_pkg::REG_SETTLE:   cfg_next.settle_ticks    = pwdata[hlc_pkg::WAIT_W-1:0];
                hlc_pkg::REG_DWELL:    cfg_next.dwell_ticks     = pwdata[hlc_pkg::WAIT_W-1:0];
                hlc_pkg::REG_MODE:     cfg_next.mode_flags      = pwdata[hlc_pkg::MODE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hlc_pkg::REG_SEARCH_X: prdata = hlc_pkg::DATA_W'(cfg_reg.search_steps_x);
            hlc_pkg::REG_SEARCH_Y: prdata = hlc_pkg::DATA_W'(cfg_reg.search_steps_y);
            hlc_pkg::REG_PULL_X:   prdata = hlc_pkg::DATA_W'(cfg_reg.pulloff_steps_x);
            hlc_pkg::REG_PULL_Y:   prdata = hlc_pkg::DATA_W'(cfg_reg.pulloff_steps_y);
            hlc_pkg::REG_STEP_LOW: prdata = hlc_pkg::DATA_W'(cfg_reg.step_low_ticks);
            hlc_pkg::REG_SETTLE:   prdata = hlc_pkg::DATA_W'(cfg_reg.settle_ticks);
            hlc_pkg::REG_DWELL:    prdata = hlc_pkg::DATA_W'(cfg_reg.dwell_ticks);
            hlc_pkg::REG_MODE:     prdata = hlc_pkg::DATA_W'(cfg_reg.mode_flags);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.search_steps_x  <= hlc_pkg::RST_SEARCH;
            cfg_reg.search_steps_y  <= hlc_pkg::RST_SEARCH;
            cfg_reg.pulloff_steps_x <= hlc_pkg::RST_PULL;
            cfg_reg.pulloff_steps_y <= hlc_pkg::RST_PULL;
            cfg_reg.step_low_ticks  <= hlc_pkg::RST_LOW;
            cfg_reg.settle_ticks    <= hlc_pkg::RST_SETTLE;
            cfg_reg.dwell_ticks     <= hlc_pkg::RST_DWELL;
            cfg_reg.mode_flags      <= hlc_pkg::RST_MODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hlc_flow.sv =====
// Input register and handshake control for the homing controller.
// Depends on hlc_pkg for the input word and flow status types.
`default_nettype none

module hlc_flow (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire hlc_pkg::item_t s_item,
    input  wire logic           m_ready,
    output hlc_pkg::item_t      item_q,
    output hlc_pkg::flow_t      flow
);

    logic           in_valid_reg;
    logic           in_valid_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    hlc_pkg::item_t item_reg;
    logic           adv;
    logic           take;

    // Advance the held word when the result slot is free or draining
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign take    = s_valid && s_ready;
    assign item_q  = item_reg;

    assign flow.adv       = adv;
    assign flow.in_valid  = in_valid_reg;
    assign flow.out_valid = out_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hlc_engine.sv =====
// Homing sequencer and hard-limit monitor: state registers and one tick of work.
// Depends on hlc_pkg for phase, config, input word and result types.
`default_nettype none

module hlc_engine #(
    parameter int STEP_HIGH_TICKS = 8,
    parameter int COUNT_WIDTH     = 24
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           adv,
    input  wire hlc_pkg::item_t item,
    input  wire hlc_pkg::cfg_t  cfg,
    output hlc_pkg::res_t       res_next
);

    localparam int WW = hlc_pkg::WAIT_W;
    localparam int SW = hlc_pkg::SEARCH_W;

    hlc_pkg::phase_t        phase_reg, phase_next;
    logic [1:0]             axis_reg, axis_next;
    logic [COUNT_WIDTH-1:0] step_reg, step_next;
    logic [WW-1:0]          wait_reg, wait_next;
    logic                   alarm_reg, alarm_next;
    logic                   drive_reg, drive_next;
    logic                   dirx_reg, dirx_next;
    logic                   diry_reg, diry_next;

    logic                   px, py, pz;
    logic [2:0]             sw;
    logic [2:0]             watched;
    logic                   hit;
    logic                   start;
    logic                   wz;
    logic [WW-1:0]          wait_dec;
    logic                   level;
    logic [WW-1:0]          pulse_wait;
    logic [SW-1:0]          limit_raw;
    logic [COUNT_WIDTH-1:0] limit_cap;
    logic                   at_limit;
    logic                   x_neg, y_neg;

    assign px         = ~item.pin_x;
    assign py         = ~item.pin_y;
    assign pz         = ~item.pin_z;
    assign sw         = {pz, py, px};
    assign watched    = cfg.mode_flags[hlc_pkg::MODE_Z_CONT] ? 3'b011 : 3'b111;
    assign hit        = cfg.mode_flags[hlc_pkg::MODE_HARD] && (|(sw & watched));
    assign start      = (item.func == hlc_pkg::FUNC_START);
    assign x_neg      = cfg.mode_flags[hlc_pkg::MODE_X_NEG];
    assign y_neg      = cfg.mode_flags[hlc_pkg::MODE_Y_NEG];
    assign wz         = (wait_reg == '0);
    assign wait_dec   = wait_reg - WW'(1);
    assign level      = (wait_dec >= WW'(cfg.step_low_ticks));
    assign pulse_wait = WW'(STEP_HIGH_TICKS) + WW'(cfg.step_low_ticks) - WW'(1);

    // Step limit for the active phase
    always_comb begin
        case (phase_reg)
            hlc_pkg::PH_SEARCH_X: limit_raw = cfg.search_steps_x;
            hlc_pkg::PH_SEARCH_Y: limit_raw = cfg.search_steps_y;
            hlc_pkg::PH_PULL_X:   limit_raw = SW'(cfg.pulloff_steps_x);
            hlc_pkg::PH_PULL_Y:   limit_raw = SW'(cfg.pulloff_steps_y);
            default:              limit_raw = '0;
        endcase
    end

    // Saturate the limit to what the step counter can reach
    generate
        if (COUNT_WIDTH >= SW) begin : g_cap_wide
            assign limit_cap = COUNT_WIDTH'(limit_raw);
        end else begin : g_cap_narrow
            assign limit_cap = (|limit_raw[SW-1:COUNT_WIDTH]) ? {COUNT_WIDTH{1'b1}}
                                                             : limit_raw[COUNT_WIDTH-1:0];
        end
    endgenerate

    assign at_limit = (step_reg >= limit_cap);

    // Next state
    always_comb begin
        phase_next = phase_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        alarm_next = alarm_reg;
        drive_next = drive_reg;
        dirx_next  = dirx_reg;
        diry_next  = diry_reg;
        if (item.func == hlc_pkg::FUNC_CLEAR) begin
            alarm_next = 1'b0;
        end
        case (phase_reg)
            hlc_pkg::PH_IDLE: begin
                if (start) begin
                    alarm_next = 1'b0;
                    drive_next = 1'b1;
                    axis_next  = item.cycle_mask;
                    step_next  = '0;
                    if (item.cycle_mask[0]) begin
                        phase_next = hlc_pkg::PH_SEARCH_X;
                        wait_next  = '0;
                    end else begin
                        phase_next = hlc_pkg::PH_SETTLE;
                        wait_next  = cfg.settle_ticks;
                    end
                end else if (hit) begin
                    alarm_next = 1'b1;
                end
            end
            hlc_pkg::PH_SEARCH_X: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else if (px) begin
                    phase_next = hlc_pkg::PH_SETTLE;
                    wait_next  = cfg.settle_ticks;
                end else if (at_limit) begin
                    phase_next = hlc_pkg::PH_IDLE;
                end else begin
                    dirx_next = x_neg;
                    step_next = step_reg + COUNT_WIDTH'(1);
                    wait_next = pulse_wait;
                end
            end
            hlc_pkg::PH_SETTLE: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else if (axis_reg[1]) begin
                    phase_next = hlc_pkg::PH_SEARCH_Y;
                    step_next  = '0;
                end else if (px && py) begin
                    phase_next = hlc_pkg::PH_DWELL;
                    wait_next  = cfg.dwell_ticks;
                end else begin
                    phase_next = hlc_pkg::PH_IDLE;
                end
            end
            hlc_pkg::PH_SEARCH_Y: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else if (py) begin
                    if (px) begin
                        phase_next = hlc_pkg::PH_DWELL;
                        wait_next  = cfg.dwell_ticks;
                    end else begin
                        phase_next = hlc_pkg::PH_IDLE;
                    end
                end else if (at_limit) begin
                    phase_next = hlc_pkg::PH_IDLE;
                end else begin
                    diry_next = y_neg;
                    step_next = step_reg + COUNT_WIDTH'(1);
                    wait_next = pulse_wait;
                end
            end
            hlc_pkg::PH_DWELL: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else begin
                    step_next = '0;
                    wait_next = '0;
                    if (axis_reg[0]) begin
                        phase_next = hlc_pkg::PH_PULL_X;
                    end else if (axis_reg[1]) begin
                        phase_next = hlc_pkg::PH_PULL_Y;
                    end else begin
                        phase_next = hlc_pkg::PH_IDLE;
                    end
                end
            end
            hlc_pkg::PH_PULL_X: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else if (at_limit) begin
                    step_next  = '0;
                    wait_next  = '0;
                    phase_next = axis_reg[1] ? hlc_pkg::PH_PULL_Y : hlc_pkg::PH_IDLE;
                end else begin
                    dirx_next = ~x_neg;
                    step_next = step_reg + COUNT_WIDTH'(1);
                    wait_next = pulse_wait;
                end
            end
            hlc_pkg::PH_PULL_Y: begin
                if (!wz) begin
                    wait_next = wait_dec;
                end else if (at_limit) begin
                    phase_next = hlc_pkg::PH_IDLE;
                end else begin
                    diry_next = ~y_neg;
                    step_next = step_reg + COUNT_WIDTH'(1);
                    wait_next = pulse_wait;
                end
            end
            default: begin
                phase_next = hlc_pkg::PH_IDLE;
            end
        endcase
    end

    // Result word
    always_comb begin
        res_next                 = '0;
        res_next.dir_x           = dirx_next;
        res_next.dir_y           = diry_next;
        res_next.drivers_enabled = drive_next;
        res_next.busy            = (phase_next != hlc_pkg::PH_IDLE);
        res_next.hard_alarm      = alarm_next;
        res_next.switch_state    = sw;
        case (phase_reg)
            hlc_pkg::PH_IDLE: begin
                res_next.stop_request = !start && hit;
            end
            hlc_pkg::PH_SEARCH_X: begin
                if (!wz) begin
                    res_next.step_x = level;
                end else if (!px) begin
                    if (at_limit) begin
                        res_next.done = 1'b1;
                        res_next.code = hlc_pkg::RC_FAIL_X;
                    end else begin
                        res_next.step_x = 1'b1;
                    end
                end
            end
            hlc_pkg::PH_SETTLE: begin
                if (wz && !axis_reg[1] && !(px && py)) begin
                    res_next.done = 1'b1;
                    res_next.code = hlc_pkg::RC_FAIL_Y;
                end
            end
            hlc_pkg::PH_SEARCH_Y: begin
                if (!wz) begin
                    res_next.step_y = level;
                end else if (py) begin
                    if (!px) begin
                        res_next.done = 1'b1;
                        res_next.code = hlc_pkg::RC_FAIL_Y;
                    end
                end else if (at_limit) begin
                    res_next.done = 1'b1;
                    res_next.code = hlc_pkg::RC_FAIL_Y;
                end else begin
                    res_next.step_y = 1'b1;
                end
            end
            hlc_pkg::PH_DWELL: begin
                if (wz && (axis_reg == 2'b00)) begin
                    res_next.done          = 1'b1;
                    res_next.code          = hlc_pkg::RC_OK;
                    res_next.zero_position = 1'b1;
                end
            end
            hlc_pkg::PH_PULL_X: begin
                if (!wz) begin
                    res_next.step_x = level;
                end else if (at_limit) begin
                    if (!axis_reg[1]) begin
                        res_next.done          = 1'b1;
                        res_next.code          = hlc_pkg::RC_OK;
                        res_next.zero_position = 1'b1;
                    end
                end else begin
                    res_next.step_x = 1'b1;
                end
            end
            hlc_pkg::PH_PULL_Y: begin
                if (!wz) begin
                    res_next.step_y = level;
                end else if (at_limit) begin
                    res_next.done          = 1'b1;
                    res_next.code          = hlc_pkg::RC_OK;
                    res_next.zero_position = 1'b1;
                end else begin
                    res_next.step_y = 1'b1;
                end
            end
            default: begin
                res_next.stop_request = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hlc_pkg::PH_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
            wait_reg  <= '0;
            alarm_reg <= 1'b0;
            drive_reg <= 1'b0;
            dirx_reg  <= 1'b0;
            diry_reg  <= 1'b0;
        end else if (adv) begin
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            alarm_reg <= alarm_next;
            drive_reg <= drive_next;
            dirx_reg  <= dirx_next;
            diry_reg  <= diry_next;
        end
    end

`ifndef SYNTHESIS
    // Leaving a homing phase for idle always reports an end pulse
    a_end_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (phase_reg != hlc_pkg::PH_IDLE) && (phase_next == hlc_pkg::PH_IDLE)
        |-> res_next.done)
        else $error("homing left busy without done pulse");

    // The monitor stays quiet while homing runs
    a_no_stop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (phase_reg != hlc_pkg::PH_IDLE) |-> !res_next.stop_request)
        else $error("stop request raised during homing");

    // A start from idle enables drivers and clears the alarm
    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (phase_reg == hlc_pkg::PH_IDLE) && start
        |=> drive_reg && !alarm_reg && (phase_reg != hlc_pkg::PH_IDLE))
        else $error("start did not arm the homing cycle");

    // A zero-position pulse only accompanies a successful end
    a_zero_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res_next.zero_position
        |-> res_next.done && (res_next.code == hlc_pkg::RC_OK) && !res_next.busy)
        else $error("zero pulse without ok completion");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/xy_homing_and_hard_limit_controller_unit.sv =====
// XY homing and hard-limit controller, top level.
// A word held in the input register moves on to the result register once the result slot is free.
// Throughput: one word per cycle while the sink is ready; the input register and result register overlap.
// Every word finishes in a single pass through the sequencer's next-state logic.
// Reset (aresetn low, synchronous): phase idle, counters, alarm and drivers cleared,
// registers back to their defaults, both channels empty.
`default_nettype none

module xy_homing_and_hard_limit_controller_unit #(
    parameter int STEP_HIGH_TICKS = 8,
    parameter int COUNT_WIDTH     = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    // Configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hlc_pkg::DATA_W-1:0] pwdata,
    output logic      [hlc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,

    // Input words: one tick or command each
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_func,
    input  wire logic [1:0]                 s_cycle_mask,
    input  wire logic                       s_pin_x,
    input  wire logic                       s_pin_y,
    input  wire logic                       s_pin_z,

    // Result words
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_step_x,
    output logic                            m_step_y,
    output logic                            m_dir_x,
    output logic                            m_dir_y,
    output logic                            m_drivers_enabled,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [1:0]                      m_result_code,
    output logic                            m_zero_position,
    output logic                            m_hard_alarm,
    output logic                            m_stop_request,
    output logic [2:0]                      m_switch_state
);

    hlc_pkg::cfg_t  cfg;
    hlc_pkg::item_t s_item;
    hlc_pkg::item_t item_q;
    hlc_pkg::flow_t flow;
    hlc_pkg::res_t  res_next;
    hlc_pkg::res_t  res_reg;

    // Gather the payload ports into one input word
    assign s_item.func       = s_func;
    assign s_item.cycle_mask = s_cycle_mask;
    assign s_item.pin_x      = s_pin_x;
    assign s_item.pin_y      = s_pin_y;
    assign s_item.pin_z      = s_pin_z;

    // Register file; the user must write it only while no word is in flight (the block does not enforce this)
    hlc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register and handshake: advance a word whenever the result slot frees up
    hlc_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_ready (m_ready),
        .item_q  (item_q),
        .flow    (flow)
    );

    // Sequencer: state moves on only when the word advances
    hlc_engine #(
        .STEP_HIGH_TICKS (STEP_HIGH_TICKS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (flow.adv),
        .item     (item_q),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // Result register: load on advance, hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (flow.adv) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = flow.out_valid;
    assign m_step_x          = res_reg.step_x;
    assign m_step_y          = res_reg.step_y;
    assign m_dir_x           = res_reg.dir_x;
    assign m_dir_y           = res_reg.dir_y;
    assign m_drivers_enabled = res_reg.drivers_enabled;
    assign m_busy_res        = res_reg.busy;
    assign m_done_res        = res_reg.done;
    assign m_result_code     = res_reg.code;
    assign m_zero_position   = res_reg.zero_position;
    assign m_hard_alarm      = res_reg.hard_alarm;
    assign m_stop_request    = res_reg.stop_request;
    assign m_switch_state    = res_reg.switch_state;

endmodule

`default_nettype wire

// ===== bench/xy_homing_and_hard_limit_controller_unit_tb.sv =====
// Self-checking bench for the XY homing and hard-limit controller: a cycle-level
// predictor checks every result word against the block under randomized flow control.
// Depends on rtl/core/hlc_pkg.sv and the xy_homing_and_hard_limit_controller_unit RTL.
`timescale 1ns / 100ps

module xy_homing_and_hard_limit_controller_unit_tb;

    import hlc_pkg::*;

    localparam int STEP_HIGH      = 8;
    localparam int COUNT_W        = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    // Raw pin levels are active low
    localparam logic PRESSED = 1'b0;
    localparam logic OPEN    = 1'b1;

    // The block treats the unused command code as a plain tick
    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    wire  [DATA_W-1:0]   prdata;
    wire                 pready;

    logic       s_valid      = 1'b0;
    wire        s_ready;
    logic [1:0] s_func       = FUNC_TICK;
    logic [1:0] s_cycle_mask = 2'b00;
    logic       s_pin_x      = OPEN;
    logic       s_pin_y      = OPEN;
    logic       s_pin_z      = OPEN;

    wire        m_valid;
    logic       m_ready = 1'b0;
    wire        m_step_x;
    wire        m_step_y;
    wire        m_dir_x;
    wire        m_dir_y;
    wire        m_drivers_enabled;
    wire        m_busy_res;
    wire        m_done_res;
    wire  [1:0] m_result_code;
    wire        m_zero_position;
    wire        m_hard_alarm;
    wire        m_stop_request;
    wire  [2:0] m_switch_state;

    xy_homing_and_hard_limit_controller_unit #(
        .STEP_HIGH_TICKS(STEP_HIGH),
        .COUNT_WIDTH    (COUNT_W)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_cycle_mask     (s_cycle_mask),
        .s_pin_x          (s_pin_x),
        .s_pin_y          (s_pin_y),
        .s_pin_z          (s_pin_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_x         (m_step_x),
        .m_step_y         (m_step_y),
        .m_dir_x          (m_dir_x),
        .m_dir_y          (m_dir_y),
        .m_drivers_enabled(m_drivers_enabled),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .m_result_code    (m_result_code),
        .m_zero_position  (m_zero_position),
        .m_hard_alarm     (m_hard_alarm),
        .m_stop_request   (m_stop_request),
        .m_switch_state   (m_switch_state)
    );

    // ------------------------------------------------------------------
    // Shadow of the homing sequencer: configuration, phase, counters and
    // latches, advanced once per accepted input word.
    // ------------------------------------------------------------------
    cfg_t               cfg_q;
    phase_t             ph_q;
    logic [1:0]         axes_q;
    logic [COUNT_W-1:0] steps_q;
    logic [WAIT_W-1:0]  tick_left_q;
    logic               alarm_q;
    logic               drive_q;
    logic               dirx_q;
    logic               diry_q;
    logic               end_flag;
    logic [1:0]         end_code;

    item_t stim_words[$];       // words waiting to be offered
    res_t  predicted_words[$];  // results owed by the block, oldest first

    int    words_queued  = 0;
    int    words_in      = 0;
    int    mismatch_cnt  = 0;

    // Close the homing cycle with a result code
    function automatic void end_cycle(input logic [1:0] code);
        ph_q     = PH_IDLE;
        end_flag = 1'b1;
        end_code = code;
    endfunction

    // Begin one step pulse: high for STEP_HIGH ticks, then low for step_low_ticks
    function automatic void launch_step();
        steps_q     = steps_q + 1'b1;
        tick_left_q = STEP_HIGH + cfg_q.step_low_ticks - 1;
    endfunction

    // Both switches must be closed before the dwell, else report a Y failure
    function automatic void check_both(input logic px, input logic py);
        if (px && py) begin
            ph_q        = PH_DWELL;
            tick_left_q = cfg_q.dwell_ticks;
        end else begin
            end_cycle(RC_FAIL_Y);
        end
    endfunction

    function automatic void begin_pull_y();
        steps_q     = '0;
        tick_left_q = '0;
        if (axes_q[1]) begin
            ph_q = PH_PULL_Y;
        end else begin
            end_cycle(RC_OK);
        end
    endfunction

    // Advance the shadow sequencer by one tick and return the result word
    function automatic res_t homing_tick(input item_t w);
        res_t       r;
        logic       px;
        logic       py;
        logic       pz;
        logic [2:0] pressed;
        logic [2:0] watched;
        r        = '0;
        px       = ~w.pin_x;
        py       = ~w.pin_y;
        pz       = ~w.pin_z;
        pressed  = {pz, py, px};
        end_flag = 1'b0;
        end_code = RC_OK;

        // Alarm clear acts in every phase, before the phase logic
        if (w.func == FUNC_CLEAR) alarm_q = 1'b0;

        case (ph_q)
            PH_IDLE: begin
                if (w.func == FUNC_START) begin
                    alarm_q     = 1'b0;
                    drive_q     = 1'b1;
                    axes_q      = w.cycle_mask;
                    steps_q     = '0;
                    tick_left_q = '0;
                    if (w.cycle_mask[0]) begin
                        ph_q = PH_SEARCH_X;
                    end else begin
                        ph_q        = PH_SETTLE;
                        tick_left_q = cfg_q.settle_ticks;
                    end
                end else if (cfg_q.mode_flags[MODE_HARD]) begin
                    // Z is left out of the monitor when it is a contact probe only
                    watched = cfg_q.mode_flags[MODE_Z_CONT] ? 3'b011 : 3'b111;
                    if ((pressed & watched) != 3'b000) begin
                        alarm_q        = 1'b1;
                        r.stop_request = 1'b1;
                    end
                end
            end
            PH_SEARCH_X: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                    r.step_x    = (tick_left_q >= cfg_q.step_low_ticks);
                end else if (px) begin
                    ph_q        = PH_SETTLE;
                    tick_left_q = cfg_q.settle_ticks;
                end else if (steps_q >= cfg_q.search_steps_x) begin
                    end_cycle(RC_FAIL_X);
                end else begin
                    dirx_q   = cfg_q.mode_flags[MODE_X_NEG];
                    r.step_x = 1'b1;
                    launch_step();
                end
            end
            PH_SETTLE: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                end else if (axes_q[1]) begin
                    ph_q    = PH_SEARCH_Y;
                    steps_q = '0;
                end else begin
                    check_both(px, py);
                end
            end
            PH_SEARCH_Y: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                    r.step_y    = (tick_left_q >= cfg_q.step_low_ticks);
                end else if (py) begin
                    check_both(px, py);
                end else if (steps_q >= cfg_q.search_steps_y) begin
                    end_cycle(RC_FAIL_Y);
                end else begin
                    diry_q   = cfg_q.mode_flags[MODE_Y_NEG];
                    r.step_y = 1'b1;
                    launch_step();
                end
            end
            PH_DWELL: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                end else begin
                    steps_q     = '0;
                    tick_left_q = '0;
                    if (axes_q[0]) begin
                        ph_q = PH_PULL_X;
                    end else begin
                        begin_pull_y();
                    end
                end
            end
            PH_PULL_X: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                    r.step_x    = (tick_left_q >= cfg_q.step_low_ticks);
                end else if (steps_q >= cfg_q.pulloff_steps_x) begin
                    begin_pull_y();
                end else begin
                    dirx_q   = ~cfg_q.mode_flags[MODE_X_NEG];
                    r.step_x = 1'b1;
                    launch_step();
                end
            end
            PH_PULL_Y: begin
                if (tick_left_q != 0) begin
                    tick_left_q = tick_left_q - 1'b1;
                    r.step_y    = (tick_left_q >= cfg_q.step_low_ticks);
                end else if (steps_q >= cfg_q.pulloff_steps_y) begin
                    end_cycle(RC_OK);
                end else begin
                    diry_q   = ~cfg_q.mode_flags[MODE_Y_NEG];
                    r.step_y = 1'b1;
                    launch_step();
                end
            end
            default: begin
                ph_q = PH_IDLE;
            end
        endcase

        r.dir_x           = dirx_q;
        r.dir_y           = diry_q;
        r.drivers_enabled = drive_q;
        r.busy            = (ph_q != PH_IDLE);
        r.done            = end_flag;
        r.code            = end_code;
        r.zero_position   = end_flag && (end_code == RC_OK);
        r.hard_alarm      = alarm_q;
        r.switch_state    = pressed;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Input driver: offer words from the stimulus queue in bursts with
    // random gaps; predict the result of each word as it is accepted.
    // ------------------------------------------------------------------
    item_t fed_word;
    item_t next_word;
    int    burst_left = 0;
    int    gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fed_word.func       = s_func;
                fed_word.cycle_mask = s_cycle_mask;
                fed_word.pin_x      = s_pin_x;
                fed_word.pin_y      = s_pin_y;
                fed_word.pin_z      = s_pin_z;
                predicted_words.push_back(homing_tick(fed_word));
                words_in <= words_in + 1;
            end
            // Hold the word while it is not taken; otherwise move on
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (stim_words.size() != 0) begin
                    next_word = stim_words.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= next_word.func;
                    s_cycle_mask <= next_word.cycle_mask;
                    s_pin_x      <= next_word.pin_x;
                    s_pin_y      <= next_word.pin_y;
                    s_pin_z      <= next_word.pin_z;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: switch between always-ready, coin-flip and sparse
    // ready; once, hold off for a long stretch so the block backs up.
    // ------------------------------------------------------------------
    int rx_mode        = 0;
    int mode_left      = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!long_hold_done && words_in >= 600) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 2);
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted word with the oldest prediction
    // ------------------------------------------------------------------
    res_t want_word;

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_words.size() == 0) begin
                $error("result word with no prediction pending");
                mismatch_cnt++;
            end else begin
                want_word = predicted_words.pop_front();
                check_field("step_x",          want_word.step_x,          m_step_x);
                check_field("step_y",          want_word.step_y,          m_step_y);
                check_field("dir_x",           want_word.dir_x,           m_dir_x);
                check_field("dir_y",           want_word.dir_y,           m_dir_y);
                check_field("drivers_enabled", want_word.drivers_enabled, m_drivers_enabled);
                check_field("busy_res",        want_word.busy,            m_busy_res);
                check_field("done_res",        want_word.done,            m_done_res);
                check_field("result_code",     want_word.code,            m_result_code);
                check_field("zero_position",   want_word.zero_position,   m_zero_position);
                check_field("hard_alarm",      want_word.hard_alarm,      m_hard_alarm);
                check_field("stop_request",    want_word.stop_request,    m_stop_request);
                check_field("switch_state",    want_word.switch_state,    m_switch_state);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] f, input logic [1:0] mask,
                             input logic x, input logic y, input logic z);
        item_t w;
        w.func       = f;
        w.cycle_mask = mask;
        w.pin_x      = x;
        w.pin_y      = y;
        w.pin_z      = z;
        stim_words.push_back(w);
        words_queued++;
    endtask

    // Fully random words; drop starts when a cycle would run too long
    task automatic push_noise(input int n, input bit starts_ok);
        logic [1:0] f;
        repeat (n) begin
            f = $urandom_range(0, 3);
            if (!starts_ok && f == FUNC_START) f = FUNC_UNDEF;
            push_word(f, $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
        end
    endtask

    // Wait until every queued word is taken and every result has come back
    task automatic drain();
        while (stim_words.size() != 0 || s_valid || predicted_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle; mirror it in the shadow
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEARCH_X: cfg_q.search_steps_x  = val[SEARCH_W-1:0];
            REG_SEARCH_Y: cfg_q.search_steps_y  = val[SEARCH_W-1:0];
            REG_PULL_X:   cfg_q.pulloff_steps_x = val[PULL_W-1:0];
            REG_PULL_Y:   cfg_q.pulloff_steps_y = val[PULL_W-1:0];
            REG_STEP_LOW: cfg_q.step_low_ticks  = val[LOW_W-1:0];
            REG_SETTLE:   cfg_q.settle_ticks    = val[WAIT_W-1:0];
            REG_DWELL:    cfg_q.dwell_ticks     = val[WAIT_W-1:0];
            default:      cfg_q.mode_flags      = val[MODE_W-1:0];
        endcase
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int         p;
        int         target;
        int         len;
        int         hit_x;
        int         hit_y;
        logic       x_raw;
        logic       y_raw;
        logic [1:0] f;

        // Shadow state matches the block's reset values
        cfg_q.search_steps_x  = RST_SEARCH;
        cfg_q.search_steps_y  = RST_SEARCH;
        cfg_q.pulloff_steps_x = RST_PULL;
        cfg_q.pulloff_steps_y = RST_PULL;
        cfg_q.step_low_ticks  = RST_LOW;
        cfg_q.settle_ticks    = RST_SETTLE;
        cfg_q.dwell_ticks     = RST_DWELL;
        cfg_q.mode_flags      = RST_MODE;
        ph_q        = PH_IDLE;
        axes_q      = '0;
        steps_q     = '0;
        tick_left_q = '0;
        alarm_q     = 1'b0;
        drive_q     = 1'b0;
        dirx_q      = 1'b0;
        diry_q      = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Hard-limit monitor at reset settings (on, Z watched)
        push_word(FUNC_TICK,  2'b00, OPEN,    OPEN,    OPEN);
        push_word(FUNC_TICK,  2'b11, OPEN,    OPEN,    PRESSED);   // Z trips the alarm
        push_word(FUNC_TICK,  2'b00, OPEN,    OPEN,    OPEN);      // alarm stays latched
        push_word(FUNC_CLEAR, 2'b00, OPEN,    OPEN,    OPEN);
        push_word(FUNC_CLEAR, 2'b00, PRESSED, OPEN,    OPEN);      // clear, then relatch
        push_word(FUNC_UNDEF, 2'b00, OPEN,    OPEN,    OPEN);      // unused code is a tick
        drain();

        // Zero limits and waits, step low of 1; mode written with junk above its width
        cfg_write(REG_SEARCH_X, 32'd0);
        cfg_write(REG_SEARCH_Y, 32'd0);
        cfg_write(REG_PULL_X,   32'd0);
        cfg_write(REG_PULL_Y,   32'd0);
        cfg_write(REG_STEP_LOW, 32'd1);
        cfg_write(REG_SETTLE,   32'd0);
        cfg_write(REG_DWELL,    32'd0);
        cfg_write(REG_MODE,     32'h0000_00FC);

        push_word(FUNC_TICK,  2'b00, OPEN,    OPEN,    PRESSED);   // Z contact only: no alarm
        push_word(FUNC_TICK,  2'b00, OPEN,    PRESSED, OPEN);      // Y trips the alarm
        push_word(FUNC_START, 2'b01, OPEN,    OPEN,    OPEN);      // start clears the alarm
        push_word(FUNC_START, 2'b10, OPEN,    OPEN,    OPEN);      // ignored; X search fails
        push_word(FUNC_START, 2'b10, PRESSED, OPEN,    OPEN);      // Y only
        push_word(FUNC_TICK,  2'b00, PRESSED, OPEN,    OPEN);
        push_word(FUNC_CLEAR, 2'b00, PRESSED, OPEN,    OPEN);      // Y search fails
        push_word(FUNC_START, 2'b00, PRESSED, PRESSED, OPEN);      // no axis selected
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);      // ok, zero pulse
        push_word(FUNC_START, 2'b11, PRESSED, PRESSED, OPEN);      // both axes
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);
        push_word(FUNC_TICK,  2'b00, PRESSED, PRESSED, OPEN);
        push_word(FUNC_START, 2'b00, OPEN,    PRESSED, OPEN);      // ignored; X pull-off ends, Y pull-off begins
        push_word(FUNC_TICK,  2'b00, OPEN,    PRESSED, OPEN);

        // Random phases, each under its own settings
        for (p = 0; p < 8; p++) begin
            // Drop the sender until the block is idle; close any open cycle
            drain();
            while (ph_q != PH_IDLE) begin
                repeat (40) push_word(FUNC_TICK, 2'b00, PRESSED, PRESSED, OPEN);
                drain();
            end

            if (p == 3) begin
                // Largest values everywhere; monitor traffic only
                cfg_write(REG_SEARCH_X, 32'hFFFF_FFFF);
                cfg_write(REG_SEARCH_Y, 32'hFFFF_FFFF);
                cfg_write(REG_PULL_X,   32'hFFFF_FFFF);
                cfg_write(REG_PULL_Y,   32'hFFFF_FFFF);
                cfg_write(REG_STEP_LOW, 32'hFFFF_FFFF);
                cfg_write(REG_SETTLE,   32'hFFFF_FFFF);
                cfg_write(REG_DWELL,    32'hFFFF_FFFF);
                cfg_write(REG_MODE,     32'hFFFF_FFFF);
                push_noise(120, 1'b0);
                continue;
            end

            if (p == 0) begin
                // Largest search limits; the switches always close
                cfg_write(REG_SEARCH_X, 32'h00FF_FFFF);
                cfg_write(REG_SEARCH_Y, 32'h00FF_FFFF);
                cfg_write(REG_PULL_X,   32'd0);
                cfg_write(REG_PULL_Y,   32'd0);
                cfg_write(REG_STEP_LOW, 32'd1);
                cfg_write(REG_SETTLE,   32'd0);
                cfg_write(REG_DWELL,    32'd0);
            end else begin
                cfg_write(REG_SEARCH_X, $urandom_range(0, 5));
                cfg_write(REG_SEARCH_Y, $urandom_range(0, 5));
                cfg_write(REG_PULL_X,   $urandom_range(0, 3));
                cfg_write(REG_PULL_Y,   $urandom_range(0, 3));
                cfg_write(REG_STEP_LOW, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
                cfg_write(REG_SETTLE,   $urandom_range(0, 6));
                cfg_write(REG_DWELL,    $urandom_range(0, 6));
            end
            cfg_write(REG_MODE, $urandom_range(0, 15));

            // Mostly homing runs: start, then ticks where each switch closes at
            // a random point (or never), with occasional pin glitches and commands
            target = words_queued + 230;
            while (words_queued < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_noise($urandom_range(4, 20), 1'b1);
                end else begin
                    len   = $urandom_range(20, 110);
                    hit_x = (p != 0 && $urandom_range(0, 4) == 0) ? len + 1
                                                                  : $urandom_range(0, len);
                    hit_y = (p != 0 && $urandom_range(0, 4) == 0) ? len + 1
                                                                  : $urandom_range(0, len);
                    push_word(FUNC_START, $urandom_range(0, 3), $urandom_range(0, 1),
                              $urandom_range(0, 1), OPEN);
                    for (int k = 0; k < len; k++) begin
                        x_raw = (k >= hit_x) ? PRESSED : OPEN;
                        y_raw = (k >= hit_y) ? PRESSED : OPEN;
                        if ($urandom_range(0, 19) == 0) x_raw = ~x_raw;
                        if ($urandom_range(0, 19) == 0) y_raw = ~y_raw;
                        f = FUNC_TICK;
                        if ($urandom_range(0, 9) == 0) f = $urandom_range(0, 3);
                        push_word(f, $urandom_range(0, 3), x_raw, y_raw,
                                  ($urandom_range(0, 3) == 0) ? PRESSED : OPEN);
                    end
                end
            end
        end

        // Let the last results come back, then a few quiet cycles
        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== xy_homing_and_hard_limit_controller_unit.f =====
rtl/core/hlc_pkg.sv
rtl/core/hlc_regs.sv
rtl/core/hlc_flow.sv
rtl/core/hlc_engine.sv
rtl/core/xy_homing_and_hard_limit_controller_unit.sv
bench/xy_homing_and_hard_limit_controller_unit_tb.sv
